### src/peqe_pkg.sv
// package for the priority event queue with expiry
// request, status and register codes used by the queue; its checker shares the status codes
// no dependencies

package peqe_pkg;

    localparam logic [2:0] REQ_ENQUEUE = 3'd0;
    localparam logic [2:0] REQ_DRAIN   = 3'd1;
    localparam logic [2:0] REQ_QUERY   = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_SET     = 3'd4;

    localparam logic [3:0] ST_ACCEPTED   = 4'd0;
    localparam logic [3:0] ST_MISSING_ID = 4'd1;
    localparam logic [3:0] ST_WRONG_SRC  = 4'd2;
    localparam logic [3:0] ST_FULL       = 4'd3;
    localparam logic [3:0] ST_DUPLICATE  = 4'd4;
    localparam logic [3:0] ST_DISPATCHED = 4'd5;
    localparam logic [3:0] ST_FOUND      = 4'd6;
    localparam logic [3:0] ST_NONE       = 4'd7;
    localparam logic [3:0] ST_CLEARED    = 4'd8;
    localparam logic [3:0] ST_ACTIVE_SET = 4'd9;
    localparam logic [3:0] ST_ID_ABSENT  = 4'd10;

    localparam logic [0:0] REG_MAX_SIZE = 1'd0;
    localparam logic [0:0] REG_TIMEOUT  = 1'd1;

    localparam logic [1:0] NO_PRIORITY = 2'd3;
    localparam int unsigned MAX_RESULTS = 16;

    localparam logic [4:0]  MAX_SIZE_RESET = 5'd16;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;

endpackage

### src/priority_event_queue_with_expiry.sv
// priority event queue with expiry, top level
// entries live in one synchronous memory walked by a sequencer
// depends on peqe_pkg
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser req_type, tdata id/priority/flags/time
// m_*       out  m_tvalid/m_tready  tuser status, tdata id/priority/count, tlast
// cfg_*     in   cfg_valid/ready    cfg_index, cfg_data
//
// one memory read per entry visited, each visit a read state then an evaluate state
// enqueue: duplicate scan over the entries, then insertion shift from the tail
// drain/query: expiry pass over all entries, then one visit per emitted or scanned entry
// reset clears control state only, memory contents are never cleared
// results wait in the output register while m_tready is low

module priority_event_queue_with_expiry
    import peqe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // irq_id, irq_priority, from_queued_source, has_id, active_flag, now_ms
    input  logic [((ID_BITS + 44) / 8) * 8-1:0] s_tdata,
    // req_type
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // entry_id, entry_priority, queue_count
    output logic [((ID_BITS + 14) / 8) * 8-1:0] m_tdata,
    // status
    output logic [3:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [0:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int OW   = ((ID_BITS + 14) / 8) * 8;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RESP   = 5'd1;
    localparam logic [4:0] S_DUP_RD = 5'd2;
    localparam logic [4:0] S_DUP_EV = 5'd3;
    localparam logic [4:0] S_INS_RD = 5'd4;
    localparam logic [4:0] S_INS_EV = 5'd5;
    localparam logic [4:0] S_INS_WR = 5'd6;
    localparam logic [4:0] S_EXP_RD = 5'd7;
    localparam logic [4:0] S_EXP_EV = 5'd8;
    localparam logic [4:0] S_POST   = 5'd9;
    localparam logic [4:0] S_DRN_RD = 5'd10;
    localparam logic [4:0] S_DRN_EV = 5'd11;
    localparam logic [4:0] S_SH_RD  = 5'd12;
    localparam logic [4:0] S_SH_EV  = 5'd13;
    localparam logic [4:0] S_QRY_RD = 5'd14;
    localparam logic [4:0] S_QRY_EV = 5'd15;
    localparam logic [4:0] S_SET_RD = 5'd16;
    localparam logic [4:0] S_SET_EV = 5'd17;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [1:0]         pri;
        logic [31:0]        stamp;
        logic               active;
    } entry_t;

    entry_t slot_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    logic [4:0]         state_reg, state_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      wptr_reg, wptr_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      take_reg, take_next;
    logic [4:0]         max_reg, max_next;
    logic [31:0]        tmo_reg, tmo_next;
    logic [2:0]         req_reg, req_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [1:0]         pri_reg, pri_next;
    logic               act_reg, act_next;
    logic [31:0]        now_reg, now_next;
    logic [3:0]         st_reg, st_next;
    logic [ID_BITS-1:0] rid_reg, rid_next;
    logic [1:0]         rpri_reg, rpri_next;
    logic               ov_reg, ov_next;
    logic [3:0]         ostat_reg, ostat_next;
    logic [ID_BITS-1:0] oid_reg, oid_next;
    logic [1:0]         opri_reg, opri_next;
    logic [4:0]         ocnt_reg, ocnt_next;
    logic               olast_reg, olast_next;

    logic               mem_re, mem_we;
    logic [AW-1:0]      mem_ra, mem_wa;
    entry_t             mem_wd;

    logic [CW-1:0]      idx_inc, wptr_dec, sh_addr, w_after;
    logic [CMPW-1:0]    fill_ext, max_ext;
    logic [31:0]        age;
    logic               keep, out_free, in_fire;
    logic [2:0]         in_req;
    logic [ID_BITS-1:0] in_id;
    logic [1:0]         in_pri;
    logic               in_src, in_hid, in_act;
    logic [31:0]        in_now;
    entry_t             new_entry;

    assign in_req = s_tuser;
    assign in_id  = s_tdata[ID_BITS-1:0];
    assign in_pri = s_tdata[ID_BITS+1:ID_BITS];
    assign in_src = s_tdata[ID_BITS+2];
    assign in_hid = s_tdata[ID_BITS+3];
    assign in_act = s_tdata[ID_BITS+4];
    assign in_now = s_tdata[ID_BITS+36:ID_BITS+5];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == S_IDLE) && !s_tvalid;
    assign out_free  = !ov_reg || m_tready;

    assign m_tvalid = ov_reg;
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = OW'({ocnt_reg, opri_reg, oid_reg});

    assign idx_inc  = idx_reg + CW'(1);
    assign wptr_dec = wptr_reg - CW'(1);
    assign sh_addr  = idx_reg + take_reg;
    assign fill_ext = CMPW'(fill_reg);
    assign max_ext  = CMPW'(max_reg);
    assign age      = now_reg - rd_data_reg.stamp;
    assign keep     = (age <= tmo_reg);
    assign w_after  = wptr_reg + CW'(keep);

    assign new_entry.id     = id_reg;
    assign new_entry.pri    = pri_reg;
    assign new_entry.stamp  = now_reg;
    assign new_entry.active = act_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        wptr_next  = wptr_reg;
        fill_next  = fill_reg;
        take_next  = take_reg;
        max_next   = max_reg;
        tmo_next   = tmo_reg;
        req_next   = req_reg;
        id_next    = id_reg;
        pri_next   = pri_reg;
        act_next   = act_reg;
        now_next   = now_reg;
        st_next    = st_reg;
        rid_next   = rid_reg;
        rpri_next  = rpri_reg;
        ov_next    = ov_reg && !m_tready;
        ostat_next = ostat_reg;
        oid_next   = oid_reg;
        opri_next  = opri_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        mem_re     = 1'b0;
        mem_ra     = idx_reg[AW-1:0];
        mem_we     = 1'b0;
        mem_wa     = idx_reg[AW-1:0];
        mem_wd     = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next  = in_req;
                    id_next   = in_id;
                    pri_next  = in_pri;
                    act_next  = in_act;
                    now_next  = in_now;
                    idx_next  = '0;
                    wptr_next = '0;
                    rid_next  = '0;
                    rpri_next = '0;
                    unique case (in_req)
                        REQ_ENQUEUE:
                        begin
                            if (!in_hid)
                            begin
                                st_next    = ST_MISSING_ID;
                                state_next = S_RESP;
                            end
                            else if (!in_src)
                            begin
                                st_next    = ST_WRONG_SRC;
                                state_next = S_RESP;
                            end
                            else if (fill_ext >= max_ext
                                     || fill_ext >= CMPW'(QUEUE_DEPTH))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (fill_reg == '0)
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                state_next = S_DUP_RD;
                            end
                        end
                        REQ_DRAIN, REQ_QUERY:
                        begin
                            state_next = (fill_reg == '0) ? S_POST : S_EXP_RD;
                        end
                        REQ_CLEAR:
                        begin
                            fill_next  = '0;
                            st_next    = ST_CLEARED;
                            state_next = S_RESP;
                        end
                        REQ_SET:
                        begin
                            if (fill_reg == '0)
                            begin
                                st_next    = ST_ID_ABSENT;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SET_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = st_reg;
                    oid_next   = rid_reg;
                    opri_next  = rpri_reg;
                    ocnt_next  = 5'(fill_reg);
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUP_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_DUP_EV;
            end
            S_DUP_EV:
            begin
                if (rd_data_reg.id == id_reg)
                begin
                    st_next    = ST_DUPLICATE;
                    state_next = S_RESP;
                end
                else if (idx_inc == fill_reg)
                begin
                    wptr_next  = fill_reg;
                    state_next = S_INS_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DUP_RD;
                end
            end
            S_INS_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = wptr_dec[AW-1:0];
                state_next = S_INS_EV;
            end
            S_INS_EV:
            begin
                mem_we = 1'b1;
                mem_wa = wptr_reg[AW-1:0];
                if (rd_data_reg.pri > pri_reg)
                begin
                    mem_wd     = rd_data_reg;
                    wptr_next  = wptr_dec;
                    state_next = (wptr_dec == '0) ? S_INS_WR : S_INS_RD;
                end
                else
                begin
                    mem_wd     = new_entry;
                    fill_next  = fill_reg + CW'(1);
                    st_next    = ST_ACCEPTED;
                    state_next = S_RESP;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = wptr_reg[AW-1:0];
                mem_wd     = new_entry;
                fill_next  = fill_reg + CW'(1);
                st_next    = ST_ACCEPTED;
                state_next = S_RESP;
            end
            S_EXP_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_EXP_EV;
            end
            S_EXP_EV:
            begin
                mem_we = keep;
                mem_wa = wptr_reg[AW-1:0];
                mem_wd = rd_data_reg;
                if (idx_inc == fill_reg)
                begin
                    fill_next  = w_after;
                    state_next = S_POST;
                end
                else
                begin
                    idx_next   = idx_inc;
                    wptr_next  = w_after;
                    state_next = S_EXP_RD;
                end
            end
            S_POST:
            begin
                idx_next = '0;
                if (fill_reg == '0)
                begin
                    st_next    = ST_NONE;
                    state_next = S_RESP;
                end
                else if (req_reg == REQ_DRAIN)
                begin
                    if (fill_ext > CMPW'(MAX_RESULTS))
                    begin
                        take_next = CW'(MAX_RESULTS);
                        fill_next = fill_reg - CW'(MAX_RESULTS);
                    end
                    else
                    begin
                        take_next = fill_reg;
                        fill_next = '0;
                    end
                    state_next = S_DRN_RD;
                end
                else
                begin
                    state_next = S_QRY_RD;
                end
            end
            S_DRN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_DRN_EV;
            end
            S_DRN_EV:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = ST_DISPATCHED;
                    oid_next   = rd_data_reg.id;
                    opri_next  = rd_data_reg.pri;
                    ocnt_next  = 5'(fill_reg);
                    olast_next = (idx_inc == take_reg);
                    if (idx_inc == take_reg)
                    begin
                        idx_next   = '0;
                        state_next = (fill_reg == '0) ? S_IDLE : S_SH_RD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_DRN_RD;
                    end
                end
            end
            S_SH_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = sh_addr[AW-1:0];
                state_next = S_SH_EV;
            end
            S_SH_EV:
            begin
                mem_we   = 1'b1;
                mem_wd   = rd_data_reg;
                idx_next = idx_inc;
                state_next = (idx_inc == fill_reg) ? S_IDLE : S_SH_RD;
            end
            S_QRY_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_QRY_EV;
            end
            S_QRY_EV:
            begin
                if (rd_data_reg.active && rd_data_reg.pri < NO_PRIORITY)
                begin
                    st_next    = ST_FOUND;
                    rid_next   = rd_data_reg.id;
                    rpri_next  = rd_data_reg.pri;
                    state_next = S_RESP;
                end
                else if (idx_inc == fill_reg)
                begin
                    st_next    = ST_NONE;
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_QRY_RD;
                end
            end
            S_SET_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SET_EV;
            end
            S_SET_EV:
            begin
                if (rd_data_reg.id == id_reg)
                begin
                    mem_we        = 1'b1;
                    mem_wd.active = act_reg;
                    st_next       = ST_ACTIVE_SET;
                    state_next    = S_RESP;
                end
                else if (idx_inc == fill_reg)
                begin
                    st_next    = ST_ID_ABSENT;
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SET_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_SIZE:
                begin
                    max_next = cfg_data[4:0];
                    if (fill_ext > CMPW'(cfg_data[4:0]))
                    begin
                        fill_next = CW'(cfg_data[4:0]);
                    end
                end
                REG_TIMEOUT:
                begin
                    tmo_next = cfg_data;
                end
                default:
                begin
                    tmo_next = tmo_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            max_reg   <= MAX_SIZE_RESET;
            tmo_reg   <= TIMEOUT_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            max_reg   <= max_next;
            tmo_reg   <= tmo_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        wptr_reg  <= wptr_next;
        take_reg  <= take_next;
        req_reg   <= req_next;
        id_reg    <= id_next;
        pri_reg   <= pri_next;
        act_reg   <= act_next;
        now_reg   <= now_next;
        st_reg    <= st_next;
        rid_reg   <= rid_next;
        rpri_reg  <= rpri_next;
        ostat_reg <= ostat_next;
        oid_reg   <= oid_next;
        opri_reg  <= opri_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

endmodule

### src/peqe_chk.sv
// port checker for the priority event queue with expiry, with its bind
// watches the stream ports of priority_event_queue_with_expiry
// depends on peqe_pkg

module peqe_chk
    import peqe_pkg::*;
#(
    parameter int ID_BITS = 8
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((ID_BITS + 14) / 8) * 8-1:0] m_tdata,
    input logic [3:0]                          m_tuser,
    input logic                                m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_ID_ABSENT)
        else $error("status code out of range");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_DISPATCHED && m_tuser != ST_FOUND
        |-> m_tdata[ID_BITS+1:0] == '0)
        else $error("id or priority set on a plain status");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_CLEARED |-> m_tdata[ID_BITS+6:ID_BITS+2] == '0)
        else $error("count not zero after clear");

    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !(s_tvalid && s_tready))
        else $error("new transfer taken in the middle of a drain");

endmodule

bind priority_event_queue_with_expiry peqe_chk #(.ID_BITS(ID_BITS)) u_peqe_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
